@@ sv/epoch_seconds_to_calendar_macros.svh @@
// Assertion macros for the epoch to calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ESC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ESC_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ sv/esc_pkg.sv @@
// Types, constants and helper functions of the epoch to calendar converter.
package esc_pkg;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned BASE_YEAR     = 1970;
   localparam int unsigned DAYS_COMMON   = 365;
   localparam int unsigned DAYS_LEAP     = 366;
   localparam int unsigned DAYS_PER_WEEK = 7;
   localparam int unsigned MONTH_MIN_DAYS = 28;
   localparam int unsigned LAST_MONTH    = 11;
   localparam int unsigned MAX_YEAR      = 2106;
   // The only century year in range that is not a leap year.
   localparam int unsigned NON_LEAP_CENTURY = 2100;
   // 1970-01-01 fell on a Thursday.
   localparam int unsigned BASE_WEEKDAY  = 4;

   localparam int unsigned SECS_W = 32;
   localparam int unsigned REM_W  = 18;
   localparam int unsigned DAYS_W = 16;
   localparam int unsigned YEAR_W = 12;
   localparam int unsigned MON_W  = 4;
   localparam int unsigned DAY_W  = 5;
   localparam int unsigned HOUR_W = 5;
   localparam int unsigned MIN_W  = 6;
   localparam int unsigned SEC_W  = 6;
   localparam int unsigned WDAY_W = 3;
   localparam int unsigned CNT_W  = 1;

   // Shared multiplier: q = (x * RECIP) >> SHIFT is exact over each step's range.
   localparam int unsigned MUL_W  = 26;
   localparam int unsigned PROD_W = 52;
   // 86400 = 128 * 675: drop the low seven bits, then divide by 675.
   localparam int unsigned DAY_PRE_SHIFT = 7;
   localparam int unsigned DAY_RECIP     = 50903317;
   localparam int unsigned DAY_SHIFT     = 35;
   localparam int unsigned HOUR_RECIP    = 149131;
   localparam int unsigned HOUR_SHIFT    = 29;
   localparam int unsigned MIN_RECIP     = 4370;
   localparam int unsigned MIN_SHIFT     = 18;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYDIV,
      ST_HOURDIV,
      ST_MINDIV,
      ST_YEAR,
      ST_MONTH,
      ST_WDAY,
      ST_DONE
   } state_type;

   // Valid over 1970..2106: 2000 is a leap year, 2100 is not.
   function automatic logic is_leap(input logic [YEAR_W-1:0] yr);
      return (yr[1:0] == 2'd0) && (yr != YEAR_W'(NON_LEAP_CENTURY));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] idx,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (idx)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // Sum of two weekday values below 7, reduced to 0..6.
   function automatic logic [WDAY_W-1:0] add_mod7(input logic [WDAY_W-1:0] a,
                                                  input logic [WDAY_W-1:0] b);
      logic [WDAY_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (WDAY_W+1)'(DAYS_PER_WEEK)) begin
         sum = sum - (WDAY_W+1)'(DAYS_PER_WEEK);
      end
      return sum[WDAY_W-1:0];
   endfunction

endpackage

@@ sv/epoch_seconds_to_calendar.sv @@
// Converter from a 32-bit epoch second count to Gregorian date, time and weekday.
//
// Usage: drive req_seconds_count and raise start while busy is low; the item
// is taken at that edge and busy rises on the next cycle. One subtractor
// serves all steps and one multiplier the divisions, under a small sequencer:
//   day count by reciprocal multiply, then time of day
//   hour by reciprocal multiply, then the remainder
//   minute by reciprocal multiply, then the second
//   year walk, one year per cycle, up to 136 years past 1970
//   month walk, one month per cycle (month index 0..11)
//   day of month reduced by 7 for the weekday
//   result beat
// One item is in flight at a time and busy drops after the beat, so a new
// item is accepted only once the last one is through. The result beat lasts
// one cycle with rsp_strobe high; the result ports are valid only during that
// beat. The receiver cannot stall. Synchronous reset returns the sequencer to
// idle with busy and rsp_strobe low.
module epoch_seconds_to_calendar (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [esc_pkg::SECS_W-1:0]        req_seconds_count,
   output logic                              rsp_strobe,
   output logic [esc_pkg::YEAR_W-1:0]        rsp_year_out,
   output logic [esc_pkg::MON_W-1:0]         rsp_month_out,
   output logic [esc_pkg::DAY_W-1:0]         rsp_day_out,
   output logic [esc_pkg::HOUR_W-1:0]        rsp_hour_out,
   output logic [esc_pkg::MIN_W-1:0]         rsp_minute_out,
   output logic [esc_pkg::SEC_W-1:0]         rsp_second_out,
   output logic [esc_pkg::WDAY_W-1:0]        rsp_weekday_out
);

`include "epoch_seconds_to_calendar_macros.svh"

   localparam int unsigned REM_W = esc_pkg::REM_W;

   esc_pkg::state_type state_ff, state_in;

   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [esc_pkg::SECS_W-1:0]     quo_ff, quo_in;
   logic [esc_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [esc_pkg::DAYS_W-1:0]     days_ff, days_in;
   logic [esc_pkg::YEAR_W-1:0]     year_ff, year_in;
   logic [esc_pkg::MON_W-1:0]      mon_ff, mon_in;
   logic [esc_pkg::DAY_W-1:0]      day_ff, day_in;
   logic [esc_pkg::HOUR_W-1:0]     hour_ff, hour_in;
   logic [esc_pkg::MIN_W-1:0]      minute_ff, minute_in;
   logic [esc_pkg::SEC_W-1:0]      second_ff, second_in;
   logic [esc_pkg::WDAY_W-1:0]     wday_ff, wday_in;

   // Shared subtractor and multiplier.
   logic [REM_W-1:0]   sub_a;
   logic [REM_W-1:0]   sub_b;
   logic [REM_W:0]     diff;
   logic               borrow;
   logic [esc_pkg::MUL_W-1:0]  mul_a;
   logic [esc_pkg::MUL_W-1:0]  mul_b;
   logic [esc_pkg::PROD_W-1:0] prod;
   logic               leap;
   logic [esc_pkg::DAY_W-1:0] mlen;
   logic               cnt_last;

   assign leap     = esc_pkg::is_leap(year_ff);
   assign mlen     = esc_pkg::month_len(mon_ff, leap);
   assign cnt_last = (cnt_ff == '0);

   // Each split first takes the quotient by reciprocal, then multiplies it back.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         esc_pkg::ST_DAYDIV: begin
            if (!cnt_last) begin
               mul_a = esc_pkg::MUL_W'(quo_ff[esc_pkg::SECS_W-1:esc_pkg::DAY_PRE_SHIFT]);
               mul_b = esc_pkg::MUL_W'(esc_pkg::DAY_RECIP);
            end else begin
               mul_a = esc_pkg::MUL_W'(days_ff);
               mul_b = esc_pkg::MUL_W'(esc_pkg::SECS_PER_DAY);
            end
         end
         esc_pkg::ST_HOURDIV: begin
            if (!cnt_last) begin
               mul_a = esc_pkg::MUL_W'(rem_ff);
               mul_b = esc_pkg::MUL_W'(esc_pkg::HOUR_RECIP);
            end else begin
               mul_a = esc_pkg::MUL_W'(hour_ff);
               mul_b = esc_pkg::MUL_W'(esc_pkg::SECS_PER_HOUR);
            end
         end
         esc_pkg::ST_MINDIV: begin
            if (!cnt_last) begin
               mul_a = esc_pkg::MUL_W'(rem_ff);
               mul_b = esc_pkg::MUL_W'(esc_pkg::MIN_RECIP);
            end else begin
               mul_a = esc_pkg::MUL_W'(minute_ff);
               mul_b = esc_pkg::MUL_W'(esc_pkg::SECS_PER_MIN);
            end
         end
         default: begin
         end
      endcase
   end

   assign prod = esc_pkg::PROD_W'(mul_a) * esc_pkg::PROD_W'(mul_b);

   always_comb begin
      sub_a = rem_ff;
      sub_b = REM_W'(esc_pkg::DAYS_PER_WEEK);
      unique case (state_ff)
         // the true remainders fit in the low bits, so a narrow subtract is exact
         esc_pkg::ST_DAYDIV: begin
            sub_a = quo_ff[REM_W-1:0];
            sub_b = prod[REM_W-1:0];
         end
         esc_pkg::ST_HOURDIV: sub_b = prod[REM_W-1:0];
         esc_pkg::ST_MINDIV:  sub_b = prod[REM_W-1:0];
         esc_pkg::ST_YEAR:    sub_b = leap ? REM_W'(esc_pkg::DAYS_LEAP)
                                           : REM_W'(esc_pkg::DAYS_COMMON);
         esc_pkg::ST_MONTH:   sub_b = REM_W'(mlen);
         default:             sub_b = REM_W'(esc_pkg::DAYS_PER_WEEK);
      endcase
   end

   assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow   = diff[REM_W];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         esc_pkg::ST_IDLE:    if (start) state_in = esc_pkg::ST_DAYDIV;
         esc_pkg::ST_DAYDIV:  if (cnt_last) state_in = esc_pkg::ST_HOURDIV;
         esc_pkg::ST_HOURDIV: if (cnt_last) state_in = esc_pkg::ST_MINDIV;
         esc_pkg::ST_MINDIV:  if (cnt_last) state_in = esc_pkg::ST_YEAR;
         esc_pkg::ST_YEAR:    if (borrow) state_in = esc_pkg::ST_MONTH;
         esc_pkg::ST_MONTH: begin
            if (borrow || (mon_ff == esc_pkg::MON_W'(esc_pkg::LAST_MONTH))) begin
               state_in = esc_pkg::ST_WDAY;
            end
         end
         esc_pkg::ST_WDAY:    if (borrow) state_in = esc_pkg::ST_DONE;
         esc_pkg::ST_DONE:    state_in = esc_pkg::ST_IDLE;
         default:             state_in = esc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      mon_in    = mon_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      wday_in   = wday_ff;
      unique case (state_ff)
         esc_pkg::ST_IDLE: begin
            if (start) begin
               rem_in  = '0;
               quo_in  = req_seconds_count;
               cnt_in  = esc_pkg::CNT_W'(1);
               year_in = esc_pkg::YEAR_W'(esc_pkg::BASE_YEAR);
               mon_in  = '0;
               wday_in = esc_pkg::WDAY_W'(esc_pkg::BASE_WEEKDAY);
            end
         end
         esc_pkg::ST_DAYDIV: begin
            if (!cnt_last) begin
               days_in = prod[esc_pkg::DAY_SHIFT +: esc_pkg::DAYS_W];
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               rem_in  = diff[REM_W-1:0];
               cnt_in  = esc_pkg::CNT_W'(1);
            end
         end
         esc_pkg::ST_HOURDIV: begin
            if (!cnt_last) begin
               hour_in = prod[esc_pkg::HOUR_SHIFT +: esc_pkg::HOUR_W];
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               rem_in  = diff[REM_W-1:0];
               cnt_in  = esc_pkg::CNT_W'(1);
            end
         end
         esc_pkg::ST_MINDIV: begin
            if (!cnt_last) begin
               minute_in = prod[esc_pkg::MIN_SHIFT +: esc_pkg::MIN_W];
               cnt_in    = cnt_ff - 1'b1;
            end else begin
               second_in = diff[esc_pkg::SEC_W-1:0];
               // load the day count for the year walk
               rem_in    = REM_W'(days_ff);
            end
         end
         esc_pkg::ST_YEAR: begin
            if (!borrow) begin
               rem_in  = diff[REM_W-1:0];
               year_in = year_ff + 1'b1;
               wday_in = esc_pkg::add_mod7(wday_ff, leap ? 3'd2 : 3'd1);
            end
         end
         esc_pkg::ST_MONTH: begin
            if (!borrow && (mon_ff != esc_pkg::MON_W'(esc_pkg::LAST_MONTH))) begin
               rem_in  = diff[REM_W-1:0];
               mon_in  = mon_ff + 1'b1;
               wday_in = esc_pkg::add_mod7(wday_ff,
                            3'(mlen - esc_pkg::DAY_W'(esc_pkg::MONTH_MIN_DAYS)));
            end else begin
               day_in = rem_ff[esc_pkg::DAY_W-1:0] + 1'b1;
            end
         end
         esc_pkg::ST_WDAY: begin
            // reduce the day offset mod 7, then fold it into the weekday
            if (!borrow) begin
               rem_in = diff[REM_W-1:0];
            end else begin
               wday_in = esc_pkg::add_mod7(wday_ff, rem_ff[esc_pkg::WDAY_W-1:0]);
            end
         end
         esc_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      mon_ff    <= mon_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      wday_ff   <= wday_in;
   end

   assign busy            = (state_ff != esc_pkg::ST_IDLE);
   assign rsp_strobe      = (state_ff == esc_pkg::ST_DONE);
   assign rsp_year_out    = year_ff;
   assign rsp_month_out   = mon_ff + 1'b1;
   assign rsp_day_out     = day_ff;
   assign rsp_hour_out    = hour_ff;
   assign rsp_minute_out  = minute_ff;
   assign rsp_second_out  = second_ff;
   assign rsp_weekday_out = wday_ff;

   `ESC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
   `ESC_ASSERT(a_beat_idle, rsp_strobe |=> !busy, "sequencer not idle after result beat")
   `ESC_NEVER(a_month_range,
      busy && (mon_ff > esc_pkg::MON_W'(esc_pkg::LAST_MONTH)), "month index out of range")
   `ESC_NEVER(a_year_range,
      busy && (year_ff > esc_pkg::YEAR_W'(esc_pkg::MAX_YEAR)), "year walk ran past range")
   `ESC_ASSERT(a_result_range,
      rsp_strobe |-> ((rsp_weekday_out < 3'd7) && (rsp_day_out != 5'd0) &&
                      (rsp_hour_out < 5'd24)), "result field out of range")

endmodule

@@ bench/epoch_seconds_to_calendar_checker.sv @@
// Checker that predicts and compares the calendar dates of the epoch converter.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [esc_pkg::SECS_W-1:0]    req_seconds_count,
   input  logic                          rsp_strobe,
   input  logic [esc_pkg::YEAR_W-1:0]    rsp_year_out,
   input  logic [esc_pkg::MON_W-1:0]     rsp_month_out,
   input  logic [esc_pkg::DAY_W-1:0]     rsp_day_out,
   input  logic [esc_pkg::HOUR_W-1:0]    rsp_hour_out,
   input  logic [esc_pkg::MIN_W-1:0]     rsp_minute_out,
   input  logic [esc_pkg::SEC_W-1:0]     rsp_second_out,
   input  logic [esc_pkg::WDAY_W-1:0]    rsp_weekday_out,
   output int unsigned                   mismatch_count,
   output int unsigned                   pending_count,
   output int unsigned                   dates_checked
);

   typedef logic [esc_pkg::SECS_W-1:0] seconds_type;
   typedef logic [esc_pkg::YEAR_W-1:0] year_type;
   typedef logic [esc_pkg::MON_W-1:0]  month_type;
   typedef logic [esc_pkg::DAY_W-1:0]  mday_type;
   typedef logic [esc_pkg::HOUR_W-1:0] hour_type;
   typedef logic [esc_pkg::MIN_W-1:0]  minute_type;
   typedef logic [esc_pkg::SEC_W-1:0]  second_type;
   typedef logic [esc_pkg::WDAY_W-1:0] weekday_type;

   typedef struct packed {
      year_type    year;
      month_type   month;
      mday_type    day;
      hour_type    hour;
      minute_type  minute;
      second_type  second;
      weekday_type weekday;
   } calendar_type;

   localparam int unsigned SECONDS_PER_DAY    = 86400;
   localparam int unsigned SECONDS_PER_HOUR   = 3600;
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam int unsigned EPOCH_YEAR         = 1970;
   localparam int unsigned MONTHS_PER_YEAR    = 12;
   localparam int unsigned REPORT_LIMIT       = 10;

   calendar_type expected_dates[$];

   function automatic logic leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned mon,
                                                input int unsigned yr);
      int unsigned len;
      case (mon)
         2:             len = leap_year(yr) ? 29 : 28;
         4, 6, 9, 11:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   // January and February count as months 13 and 14 of the year before.
   function automatic weekday_type zeller_weekday(input int unsigned yr,
                                                  input int unsigned mon,
                                                  input int unsigned dom);
      int cent, yoc, m, d, sum, rem;
      if (mon <= 2) begin
         mon = mon + 12;
         yr  = yr - 1;
      end
      cent = yr / 100;
      yoc  = yr % 100;
      m    = mon;
      d    = dom;
      sum  = cent / 4 - 2 * cent + yoc + yoc / 4 + (26 * (m + 1)) / 10 + d - 1;
      rem  = sum % 7;
      if (rem < 0) begin
         rem = rem + 7;
      end
      return weekday_type'(rem);
   endfunction

   function automatic calendar_type calendar_of(input seconds_type secs);
      calendar_type cal;
      int unsigned  day_num, time_of_day, yr, mon, year_days;
      day_num     = secs / SECONDS_PER_DAY;
      time_of_day = secs % SECONDS_PER_DAY;
      yr          = EPOCH_YEAR;
      forever begin
         year_days = leap_year(yr) ? 366 : 365;
         if (day_num < year_days) break;
         day_num = day_num - year_days;
         yr++;
      end
      mon = 1;
      while (mon < MONTHS_PER_YEAR && day_num >= month_length(mon, yr)) begin
         day_num = day_num - month_length(mon, yr);
         mon++;
      end
      cal.year    = year_type'(yr);
      cal.month   = month_type'(mon);
      cal.day     = mday_type'(day_num + 1);
      cal.hour    = hour_type'(time_of_day / SECONDS_PER_HOUR);
      cal.minute  = minute_type'((time_of_day % SECONDS_PER_HOUR) / SECONDS_PER_MINUTE);
      cal.second  = second_type'(time_of_day % SECONDS_PER_MINUTE);
      cal.weekday = zeller_weekday(yr, mon, day_num + 1);
      return cal;
   endfunction

   always @(posedge clock) begin : track
      calendar_type seen, want;
      if (reset) begin
         expected_dates.delete();
         pending_count <= 0;
      end else begin
         if (start && !busy) begin
            expected_dates.push_back(calendar_of(req_seconds_count));
         end
         if (rsp_strobe) begin
            seen = '{rsp_year_out, rsp_month_out, rsp_day_out, rsp_hour_out,
                     rsp_minute_out, rsp_second_out, rsp_weekday_out};
            if (expected_dates.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: result beat with no date pending: %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                           $realtime, seen.year, seen.month, seen.day, seen.hour,
                           seen.minute, seen.second, seen.weekday);
               end
            end else begin
               want = expected_dates.pop_front();
               dates_checked++;
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                              $realtime, want.year, want.month, want.day, want.hour,
                              want.minute, want.second, want.weekday);
                     $display("   got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                              seen.year, seen.month, seen.day, seen.hour,
                              seen.minute, seen.second, seen.weekday);
                  end
               end
            end
         end
         pending_count <= expected_dates.size();
      end
   end

endmodule

@@ bench/epoch_seconds_to_calendar_tb.sv @@
// Testbench top that drives epoch second counts into the calendar converter.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

   localparam int          CLOCK_PERIOD  = 2;
   localparam int unsigned RESET_CYCLES  = 11;
   localparam int unsigned RANDOM_ITEMS  = 1980;
   localparam int unsigned CALM_ITEMS    = 300;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned LAST_DAY      = 49710;
   localparam int unsigned SECONDS_PER_DAY = 86400;
   localparam int          CORNER_TOTAL  = 21;

   // Day zero, end of day, year ends, leap days around 1972 and 2000, the
   // 2038 sign boundary, the non-leap year 2100, bit patterns and full range.
   localparam logic [CORNER_TOTAL-1:0][31:0] CORNER_COUNTS = {
      32'd0,          32'd59,         32'd3599,       32'd86399,
      32'd86400,      32'd31535999,   32'd31536000,   32'd68169600,
      32'd951868799,  32'd951868800,  32'd978307199,  32'd2147483647,
      32'd2147483648, 32'd4102444799, 32'd4102444800, 32'd4107542399,
      32'd4107542400, 32'd4291747200, 32'hAAAAAAAA,   32'h55555555,
      32'hFFFFFFFF
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [esc_pkg::SECS_W-1:0]    req_seconds_count = '0;
   logic                          rsp_strobe;
   logic [esc_pkg::YEAR_W-1:0]    rsp_year_out;
   logic [esc_pkg::MON_W-1:0]     rsp_month_out;
   logic [esc_pkg::DAY_W-1:0]     rsp_day_out;
   logic [esc_pkg::HOUR_W-1:0]    rsp_hour_out;
   logic [esc_pkg::MIN_W-1:0]     rsp_minute_out;
   logic [esc_pkg::SEC_W-1:0]     rsp_second_out;
   logic [esc_pkg::WDAY_W-1:0]    rsp_weekday_out;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned dates_checked;
   int unsigned counts_sent  = 0;
   int unsigned stall_cycles = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   epoch_seconds_to_calendar dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_seconds_count (req_seconds_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_year_out      (rsp_year_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_day_out       (rsp_day_out),
      .rsp_hour_out      (rsp_hour_out),
      .rsp_minute_out    (rsp_minute_out),
      .rsp_second_out    (rsp_second_out),
      .rsp_weekday_out   (rsp_weekday_out)
   );

   epoch_seconds_to_calendar_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_seconds_count (req_seconds_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_year_out      (rsp_year_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_day_out       (rsp_day_out),
      .rsp_hour_out      (rsp_hour_out),
      .rsp_minute_out    (rsp_minute_out),
      .rsp_second_out    (rsp_second_out),
      .rsp_weekday_out   (rsp_weekday_out),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .dates_checked     (dates_checked)
   );

   function automatic logic [31:0] random_seconds();
      logic [31:0] midnight;
      midnight = $urandom_range(0, LAST_DAY) * SECONDS_PER_DAY;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6:          return midnight + $urandom_range(0, 3);
         7:             return midnight - $urandom_range(1, 3);
         8:             return $urandom_range(0, 100000000);
         default:       return $urandom_range(32'd4100000000, 32'hFFFFFFFF);
      endcase
   endfunction

   task automatic idle_for(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold the beat until the converter takes it.
   task automatic send_seconds(input logic [31:0] secs);
      req_seconds_count <= secs;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      counts_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Abort when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("epoch_seconds_to_calendar_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = CORNER_TOTAL - 1; n >= 0; n--) begin
         if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 17));
         send_seconds(CORNER_COUNTS[n]);
      end
      drain();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain();
         // Alternate stretches with and without gaps; keep the tail gap-free.
         if (n < RANDOM_ITEMS - CALM_ITEMS && (n / 150) % 2 == 0 &&
             $urandom_range(0, 2) == 0) begin
            idle_for($urandom_range(1, 17));
         end
         send_seconds(random_seconds());
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d second counts (day zero, leap days, 2100, full range, random) and",
               counts_sent);
      $display("checked %0d converted dates, %0d mismatches", dates_checked, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("epoch_seconds_to_calendar_tb passed");
      end else begin
         $display("epoch_seconds_to_calendar_tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/esc_pkg.sv
sv/epoch_seconds_to_calendar.sv
bench/epoch_seconds_to_calendar_checker.sv
bench/epoch_seconds_to_calendar_tb.sv
